@@ src/cshn_pkg.sv @@
// ============================================================================
// Color sensor HSV normalizer package
// Register indexes, reset values, fixed-point constants and internal codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cshn_pkg;

   // Register indexes on the write port.
   localparam logic [2:0] CFG_CONTROL        = 3'd0;
   localparam logic [2:0] CFG_BLACK_RED      = 3'd1;
   localparam logic [2:0] CFG_WHITE_RED      = 3'd2;
   localparam logic [2:0] CFG_BLACK_GREEN    = 3'd3;
   localparam logic [2:0] CFG_WHITE_GREEN    = 3'd4;
   localparam logic [2:0] CFG_BLACK_BLUE     = 3'd5;
   localparam logic [2:0] CFG_WHITE_BLUE     = 3'd6;
   localparam logic [2:0] CFG_REFLECT_LIMITS = 3'd7;

   // Register reset values.
   localparam logic [2:0]  CONTROL_RESET     = 3'd3;
   localparam logic [9:0]  BLACK_RED_RESET   = 10'd0;
   localparam logic [9:0]  WHITE_RED_RESET   = 10'd95;
   localparam logic [9:0]  BLACK_GREEN_RESET = 10'd0;
   localparam logic [9:0]  WHITE_GREEN_RESET = 10'd85;
   localparam logic [9:0]  BLACK_BLUE_RESET  = 10'd0;
   localparam logic [9:0]  WHITE_BLUE_RESET  = 10'd100;
   localparam logic [15:0] REFLECT_RESET     = 16'd9222;

   // Control flag bit positions.
   localparam int CTRL_COLOR  = 0;
   localparam int CTRL_NORM   = 1;
   localparam int CTRL_OFFSET = 2;

   // Channel scaling outcome.
   localparam logic [1:0] CH_DIV  = 2'd0;
   localparam logic [1:0] CH_ZERO = 2'd1;
   localparam logic [1:0] CH_FULL = 2'd2;

   // Brightness level outcome.
   localparam logic [1:0] LV_DIV  = 2'd0;
   localparam logic [1:0] LV_ZERO = 2'd1;
   localparam logic [1:0] LV_SAT  = 2'd2;

   // Fixed-point constants.
   localparam logic [14:0] FULL_PCT   = 15'd25600;
   localparam logic [15:0] OFFSET_PCT = 16'd7680;
   localparam logic [15:0] LEVEL_ONE  = 16'd16384;

   // Hue sector bases in degrees times 64.
   localparam logic [14:0] HUE_BASE_0   = 15'd0;
   localparam logic [14:0] HUE_BASE_120 = 15'd7680;
   localparam logic [14:0] HUE_BASE_240 = 15'd15360;
   localparam logic [14:0] HUE_BASE_360 = 15'd23040;

   // Luma weights in Q16.
   localparam logic [15:0] LUMA_R     = 16'd19589;
   localparam logic [15:0] LUMA_G     = 16'd38444;
   localparam logic [15:0] LUMA_B     = 16'd7502;
   localparam logic [30:0] LUMA_ROUND = 31'd32768;

endpackage

`default_nettype wire

@@ src/cshn_div_pipe.sv @@
// ============================================================================
// Pipelined restoring divider
// One quotient bit per stage, most significant first. The numerator must be
// below the divisor shifted left by the quotient width.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cshn_div_pipe #(
   parameter int NW = 26,
   parameter int DW = 11,
   parameter int QW = 15
) (
   input  wire logic          clock,
   input  wire logic [QW-1:0] stage_en,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic      [QW-1:0] quo
);

   localparam int CW = DW + QW;

   logic [CW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   generate
      for (genvar k = 0; k < QW; k++) begin : g_stage
         logic [CW-1:0] rem_prev;
         logic [QW-1:0] quo_prev;
         logic [DW-1:0] den_in;
         logic [CW-1:0] rem_in;
         logic [QW-1:0] quo_in;
         logic [CW-1:0] shifted;
         logic [CW:0]   trial;

         if (k == 0) begin : g_first
            assign rem_prev = CW'(num);
            assign den_in   = den;
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign den_in   = den_ff[k-1];
            assign quo_prev = quo_ff[k-1];
         end

         always_comb begin
            shifted = CW'(den_in) << (QW - 1 - k);
            trial   = {1'b0, rem_prev} - {1'b0, shifted};
            if (trial[CW]) begin
               rem_in = rem_prev;
               quo_in = {quo_prev[QW-2:0], 1'b0};
            end else begin
               rem_in = trial[CW-1:0];
               quo_in = {quo_prev[QW-2:0], 1'b1};
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_in;
               quo_ff[k] <= quo_in;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QW-1];

endmodule

`default_nettype wire

@@ src/color_sensor_hsv_normalizer_unit.sv @@
// ============================================================================
// Color sensor HSV normalizer
// Calibrates raw RGB readings to percent, converts them to hue, saturation
// and value, and forms brightness and a normalized brightness level.
// ============================================================================
// Throughput: one beat per cycle while rsp_stall is low; 38 pipeline stages,
// set by two banks of pipelined dividers (15 and 14 quotient bits, one bit
// per stage) plus prep stages.
// A stalled output only holds stages that are full; bubbles close up.
// Reset clears all stage valid bits and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module color_sensor_hsv_normalizer_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_addr,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [9:0]         req_raw_red,
   input  wire logic [9:0]         req_raw_green,
   input  wire logic [9:0]         req_raw_blue,
   input  wire logic [6:0]         req_reflect,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_color_valid,
   output logic [14:0]             rsp_norm_red,
   output logic [14:0]             rsp_norm_green,
   output logic [14:0]             rsp_norm_blue,
   output logic [14:0]             rsp_hue,
   output logic [12:0]             rsp_saturation,
   output logic [15:0]             rsp_value,
   output logic [14:0]             rsp_brightness,
   output logic signed [15:0]      rsp_brightness_level
);

   localparam int Q1    = 15;
   localparam int Q2    = 14;
   localparam int P_IN  = 0;
   localparam int P_CH  = 1;
   localparam int P_CD  = 2;
   localparam int P_D1  = 3;
   localparam int P_CF  = P_D1 + Q1;
   localparam int P_H1  = P_CF + 1;
   localparam int P_H2  = P_H1 + 1;
   localparam int P_H3  = P_H2 + 1;
   localparam int P_H4  = P_H3 + 1;
   localparam int P_D2  = P_H4 + 1;
   localparam int P_OUT = P_D2 + Q2;
   localparam int NSTG  = P_OUT + 1;

   typedef struct packed {
      logic [1:0] code;
      logic [9:0] mag;
      logic [9:0] span;
   } ch_prep_type;

   typedef struct packed {
      logic [1:0] code_r;
      logic [1:0] code_g;
      logic [1:0] code_b;
      logic [6:0] refl;
   } side1_type;

   typedef struct packed {
      logic [27:0] hue_num;
      logic [16:0] hue_den;
      logic [28:0] sat_num;
      logic [16:0] sat_den;
      logic [15:0] value;
      logic        hue_neg;
      logic [14:0] hue_base;
      logic        hue_zero;
      logic        top_zero;
      logic [14:0] nr;
      logic [14:0] ng;
      logic [14:0] nb;
      logic [14:0] bright;
   } hsv_type;

   typedef struct packed {
      logic [15:0] value;
      logic        hue_neg;
      logic [14:0] hue_base;
      logic        hue_zero;
      logic        top_zero;
      logic [14:0] nr;
      logic [14:0] ng;
      logic [14:0] nb;
      logic [14:0] bright;
      logic [1:0]  lv_code;
      logic        lv_neg;
   } side2_type;

   function automatic ch_prep_type ch_prep(input logic [9:0] raw, input logic [9:0] black,
                                           input logic [9:0] white);
      logic signed [11:0] n;
      logic signed [11:0] d;
      ch_prep_type        p;
      n = $signed({2'b00, raw}) - $signed({2'b00, black});
      d = $signed({2'b00, white}) - $signed({2'b00, black});
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      p.mag  = n[9:0];
      p.span = d[9:0];
      if (d == 0) begin
         p.code = (n > 0) ? cshn_pkg::CH_FULL : cshn_pkg::CH_ZERO;
      end else if (n <= 0) begin
         p.code = cshn_pkg::CH_ZERO;
      end else if (n >= d) begin
         p.code = cshn_pkg::CH_FULL;
      end else begin
         p.code = cshn_pkg::CH_DIV;
      end
      return p;
   endfunction

   function automatic logic [14:0] ch_final(input logic [1:0] code, input logic [14:0] q);
      logic [14:0] r;
      case (code)
         cshn_pkg::CH_FULL: r = cshn_pkg::FULL_PCT;
         cshn_pkg::CH_ZERO: r = '0;
         default:           r = q;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [2:0]  ctrl_ff;
   logic [9:0]  black_r_ff, white_r_ff, black_g_ff, white_g_ff, black_b_ff, white_b_ff;
   logic [15:0] reflect_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff        <= cshn_pkg::CONTROL_RESET;
         black_r_ff     <= cshn_pkg::BLACK_RED_RESET;
         white_r_ff     <= cshn_pkg::WHITE_RED_RESET;
         black_g_ff     <= cshn_pkg::BLACK_GREEN_RESET;
         white_g_ff     <= cshn_pkg::WHITE_GREEN_RESET;
         black_b_ff     <= cshn_pkg::BLACK_BLUE_RESET;
         white_b_ff     <= cshn_pkg::WHITE_BLUE_RESET;
         reflect_lim_ff <= cshn_pkg::REFLECT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            cshn_pkg::CFG_CONTROL:        ctrl_ff        <= csr_wdata[2:0];
            cshn_pkg::CFG_BLACK_RED:      black_r_ff     <= csr_wdata[9:0];
            cshn_pkg::CFG_WHITE_RED:      white_r_ff     <= csr_wdata[9:0];
            cshn_pkg::CFG_BLACK_GREEN:    black_g_ff     <= csr_wdata[9:0];
            cshn_pkg::CFG_WHITE_GREEN:    white_g_ff     <= csr_wdata[9:0];
            cshn_pkg::CFG_BLACK_BLUE:     black_b_ff     <= csr_wdata[9:0];
            cshn_pkg::CFG_WHITE_BLUE:     white_b_ff     <= csr_wdata[9:0];
            cshn_pkg::CFG_REFLECT_LIMITS: reflect_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   wire logic color_mode = ctrl_ff[cshn_pkg::CTRL_COLOR];

   // -------------------------------------------------------- stage control
   // A stage may load unless it and every stage after it are full while the
   // output beat is stalled.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] stg_en;

   always_comb begin
      for (int i = 0; i < NSTG; i++) begin
         stg_en[i] = !rsp_stall ||
                     !(&(vld_ff | ((NSTG'(1) << i) - NSTG'(1))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (stg_en[i]) begin
               vld_ff[i] <= (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_stall = !stg_en[0];
   assign rsp_valid = vld_ff[NSTG-1];

   // --------------------------------------------------------- input stage
   logic [9:0] in_r_ff, in_g_ff, in_b_ff;
   logic [6:0] in_refl_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_IN]) begin
         in_r_ff    <= req_raw_red;
         in_g_ff    <= req_raw_green;
         in_b_ff    <= req_raw_blue;
         in_refl_ff <= req_reflect;
      end
   end

   // ------------------------------------------------- channel span classify
   ch_prep_type ch_r_ff, ch_g_ff, ch_b_ff;
   logic [6:0]  ch_refl_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_CH]) begin
         ch_r_ff    <= ch_prep(in_r_ff, black_r_ff, white_r_ff);
         ch_g_ff    <= ch_prep(in_g_ff, black_g_ff, white_g_ff);
         ch_b_ff    <= ch_prep(in_b_ff, black_b_ff, white_b_ff);
         ch_refl_ff <= in_refl_ff;
      end
   end

   // ------------------------------------------------ channel divider inputs
   // Rounded quotient: (2*25600*n + d) / (2*d).
   logic [25:0] cd_num_r_ff, cd_num_g_ff, cd_num_b_ff;
   logic [10:0] cd_den_r_ff, cd_den_g_ff, cd_den_b_ff;
   side1_type   cd_side_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_CD]) begin
         cd_num_r_ff       <= 26'(ch_r_ff.mag) * 26'd51200 + 26'(ch_r_ff.span);
         cd_num_g_ff       <= 26'(ch_g_ff.mag) * 26'd51200 + 26'(ch_g_ff.span);
         cd_num_b_ff       <= 26'(ch_b_ff.mag) * 26'd51200 + 26'(ch_b_ff.span);
         cd_den_r_ff       <= {ch_r_ff.span, 1'b0};
         cd_den_g_ff       <= {ch_g_ff.span, 1'b0};
         cd_den_b_ff       <= {ch_b_ff.span, 1'b0};
         cd_side_ff.code_r <= ch_r_ff.code;
         cd_side_ff.code_g <= ch_g_ff.code;
         cd_side_ff.code_b <= ch_b_ff.code;
         cd_side_ff.refl   <= ch_refl_ff;
      end
   end

   logic [Q1-1:0] quo_r, quo_g, quo_b;

   cshn_div_pipe #(.NW(26), .DW(11), .QW(Q1)) u_div_red (
      .clock   (clock),
      .stage_en(stg_en[P_D1 +: Q1]),
      .num     (cd_num_r_ff),
      .den     (cd_den_r_ff),
      .quo     (quo_r)
   );

   cshn_div_pipe #(.NW(26), .DW(11), .QW(Q1)) u_div_green (
      .clock   (clock),
      .stage_en(stg_en[P_D1 +: Q1]),
      .num     (cd_num_g_ff),
      .den     (cd_den_g_ff),
      .quo     (quo_g)
   );

   cshn_div_pipe #(.NW(26), .DW(11), .QW(Q1)) u_div_blue (
      .clock   (clock),
      .stage_en(stg_en[P_D1 +: Q1]),
      .num     (cd_num_b_ff),
      .den     (cd_den_b_ff),
      .quo     (quo_b)
   );

   side1_type side1_ff [Q1];

   always_ff @(posedge clock) begin
      for (int k = 0; k < Q1; k++) begin
         if (stg_en[P_D1 + k]) begin
            side1_ff[k] <= (k == 0) ? cd_side_ff : side1_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // ------------------------------------------------------ channel results
   logic [14:0] cf_r_ff, cf_g_ff, cf_b_ff;
   logic [6:0]  cf_refl_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_CF]) begin
         cf_r_ff    <= color_mode ? ch_final(side1_ff[Q1-1].code_r, quo_r) : '0;
         cf_g_ff    <= color_mode ? ch_final(side1_ff[Q1-1].code_g, quo_g) : '0;
         cf_b_ff    <= color_mode ? ch_final(side1_ff[Q1-1].code_b, quo_b) : '0;
         cf_refl_ff <= side1_ff[Q1-1].refl;
      end
   end

   // ------------------------------------------------ hexcone sector select
   logic [15:0] hx_r, hx_g, hx_b, hx_off;
   logic [15:0] hx_top, hx_diff, hx_numa;
   logic        hx_neg;
   logic [14:0] hx_base;

   // Sectors are tried in order and the last match wins, so pure red lands
   // in the sector that reports 360 degrees.
   always_comb begin
      hx_off  = ctrl_ff[cshn_pkg::CTRL_OFFSET] ? cshn_pkg::OFFSET_PCT : '0;
      hx_r    = 16'(cf_r_ff) + hx_off;
      hx_g    = 16'(cf_g_ff) + hx_off;
      hx_b    = 16'(cf_b_ff) + hx_off;
      hx_top  = '0;
      hx_diff = '0;
      hx_numa = '0;
      hx_neg  = 1'b0;
      hx_base = cshn_pkg::HUE_BASE_0;
      if (hx_r >= hx_g && hx_g >= hx_b) begin
         hx_top = hx_r; hx_diff = hx_r - hx_b; hx_numa = hx_g - hx_b;
         hx_neg = 1'b0; hx_base = cshn_pkg::HUE_BASE_0;
      end
      if (hx_r >= hx_b && hx_b >= hx_g) begin
         hx_top = hx_r; hx_diff = hx_r - hx_g; hx_numa = hx_b - hx_g;
         hx_neg = 1'b1; hx_base = cshn_pkg::HUE_BASE_360;
      end
      if (hx_g >= hx_r && hx_r >= hx_b) begin
         hx_top = hx_g; hx_diff = hx_g - hx_b; hx_numa = hx_r - hx_b;
         hx_neg = 1'b1; hx_base = cshn_pkg::HUE_BASE_120;
      end
      if (hx_g >= hx_b && hx_b >= hx_r) begin
         hx_top = hx_g; hx_diff = hx_g - hx_r; hx_numa = hx_b - hx_r;
         hx_neg = 1'b0; hx_base = cshn_pkg::HUE_BASE_120;
      end
      if (hx_b >= hx_r && hx_r >= hx_g) begin
         hx_top = hx_b; hx_diff = hx_b - hx_g; hx_numa = hx_r - hx_g;
         hx_neg = 1'b0; hx_base = cshn_pkg::HUE_BASE_240;
      end
      if (hx_b >= hx_g && hx_g >= hx_r) begin
         hx_top = hx_b; hx_diff = hx_b - hx_r; hx_numa = hx_g - hx_r;
         hx_neg = 1'b1; hx_base = cshn_pkg::HUE_BASE_240;
      end
   end

   logic [15:0] h1_top_ff, h1_diff_ff, h1_numa_ff;
   logic        h1_neg_ff;
   logic [14:0] h1_base_ff;
   logic [29:0] h1_pr_ff, h1_pg_ff;
   logic [27:0] h1_pb_ff;
   logic [14:0] h1_r_ff, h1_g_ff, h1_b_ff;
   logic [6:0]  h1_refl_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_H1]) begin
         h1_top_ff  <= hx_top;
         h1_diff_ff <= hx_diff;
         h1_numa_ff <= hx_numa;
         h1_neg_ff  <= hx_neg;
         h1_base_ff <= hx_base;
         h1_pr_ff   <= 30'(cf_r_ff) * 30'(cshn_pkg::LUMA_R);
         h1_pg_ff   <= 30'(cf_g_ff) * 30'(cshn_pkg::LUMA_G);
         h1_pb_ff   <= 28'(cf_b_ff) * 28'(cshn_pkg::LUMA_B);
         h1_r_ff    <= cf_r_ff;
         h1_g_ff    <= cf_g_ff;
         h1_b_ff    <= cf_b_ff;
         h1_refl_ff <= cf_refl_ff;
      end
   end

   // ------------------------------------- hue and saturation operands, luma
   logic [30:0] luma_sum;
   hsv_type     h2_in;

   always_comb begin
      luma_sum       = 31'(h1_pr_ff) + 31'(h1_pg_ff) + 31'(h1_pb_ff) + cshn_pkg::LUMA_ROUND;
      h2_in.hue_num  = 28'(h1_numa_ff) * 28'd7680 + 28'(h1_diff_ff);
      h2_in.hue_den  = {h1_diff_ff, 1'b0};
      h2_in.sat_num  = {h1_diff_ff, 13'b0} + 29'(h1_top_ff);
      h2_in.sat_den  = {h1_top_ff, 1'b0};
      h2_in.value    = h1_top_ff;
      h2_in.hue_neg  = h1_neg_ff;
      h2_in.hue_base = h1_base_ff;
      h2_in.hue_zero = (h1_diff_ff == '0);
      h2_in.top_zero = (h1_top_ff == '0);
      h2_in.nr       = h1_r_ff;
      h2_in.ng       = h1_g_ff;
      h2_in.nb       = h1_b_ff;
      h2_in.bright   = color_mode ? luma_sum[30:16] : {h1_refl_ff, 8'b0};
   end

   hsv_type    h2_ff;
   logic [6:0] h2_refl_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_H2]) begin
         h2_ff      <= h2_in;
         h2_refl_ff <= h1_refl_ff;
      end
   end

   // ------------------------------------------------ brightness level prep
   logic signed [17:0] lv_n, lv_d;
   logic [17:0]        lv_mag;
   logic [1:0]         lv_code;

   always_comb begin
      if (color_mode) begin
         lv_n = $signed({2'b00, h2_ff.bright, 1'b0}) - 18'sd25600;
         lv_d = 18'sd25600;
      end else begin
         lv_n = $signed({10'b0, h2_refl_ff, 1'b0}) - $signed({10'b0, reflect_lim_ff[7:0]})
                - $signed({10'b0, reflect_lim_ff[15:8]});
         lv_d = $signed({10'b0, reflect_lim_ff[15:8]}) - $signed({10'b0, reflect_lim_ff[7:0]});
      end
      if (lv_d < 0) begin
         lv_n = -lv_n;
         lv_d = -lv_d;
      end
      lv_mag = (lv_n < 0) ? 18'(-lv_n) : 18'(lv_n);
      if (lv_d == 0) begin
         lv_code = (lv_n == 0) ? cshn_pkg::LV_ZERO : cshn_pkg::LV_SAT;
      end else if (lv_mag >= 18'(lv_d)) begin
         lv_code = cshn_pkg::LV_SAT;
      end else begin
         lv_code = cshn_pkg::LV_DIV;
      end
   end

   hsv_type     h3_ff;
   logic [1:0]  h3_lv_code_ff;
   logic        h3_lv_neg_ff;
   logic [14:0] h3_lv_mag_ff, h3_lv_den_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_H3]) begin
         h3_ff         <= h2_ff;
         h3_lv_code_ff <= lv_code;
         h3_lv_neg_ff  <= (lv_n < 0);
         h3_lv_mag_ff  <= lv_mag[14:0];
         h3_lv_den_ff  <= lv_d[14:0];
      end
   end

   // Rounded quotient: (2*16384*|n| + d) / (2*d).
   hsv_type     h4_ff;
   logic [1:0]  h4_lv_code_ff;
   logic        h4_lv_neg_ff;
   logic [29:0] h4_lv_num_ff;
   logic [15:0] h4_lv_den_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_H4]) begin
         h4_ff         <= h3_ff;
         h4_lv_code_ff <= h3_lv_code_ff;
         h4_lv_neg_ff  <= h3_lv_neg_ff;
         h4_lv_num_ff  <= {h3_lv_mag_ff, 15'b0} + 30'(h3_lv_den_ff);
         h4_lv_den_ff  <= {h3_lv_den_ff, 1'b0};
      end
   end

   logic [Q2-1:0] quo_hue, quo_sat, quo_lv;

   cshn_div_pipe #(.NW(28), .DW(17), .QW(Q2)) u_div_hue (
      .clock   (clock),
      .stage_en(stg_en[P_D2 +: Q2]),
      .num     (h4_ff.hue_num),
      .den     (h4_ff.hue_den),
      .quo     (quo_hue)
   );

   cshn_div_pipe #(.NW(29), .DW(17), .QW(Q2)) u_div_sat (
      .clock   (clock),
      .stage_en(stg_en[P_D2 +: Q2]),
      .num     (h4_ff.sat_num),
      .den     (h4_ff.sat_den),
      .quo     (quo_sat)
   );

   cshn_div_pipe #(.NW(30), .DW(16), .QW(Q2)) u_div_level (
      .clock   (clock),
      .stage_en(stg_en[P_D2 +: Q2]),
      .num     (h4_lv_num_ff),
      .den     (h4_lv_den_ff),
      .quo     (quo_lv)
   );

   side2_type side2_in;
   side2_type side2_ff [Q2];

   always_comb begin
      side2_in.value    = h4_ff.value;
      side2_in.hue_neg  = h4_ff.hue_neg;
      side2_in.hue_base = h4_ff.hue_base;
      side2_in.hue_zero = h4_ff.hue_zero;
      side2_in.top_zero = h4_ff.top_zero;
      side2_in.nr       = h4_ff.nr;
      side2_in.ng       = h4_ff.ng;
      side2_in.nb       = h4_ff.nb;
      side2_in.bright   = h4_ff.bright;
      side2_in.lv_code  = h4_lv_code_ff;
      side2_in.lv_neg   = h4_lv_neg_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Q2; k++) begin
         if (stg_en[P_D2 + k]) begin
            side2_ff[k] <= (k == 0) ? side2_in : side2_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // --------------------------------------------------------- output stage
   side2_type          sd;
   logic [14:0]        out_hue;
   logic [12:0]        out_sat;
   logic signed [15:0] out_level;

   always_comb begin
      sd = side2_ff[Q2-1];
      // A saturation that rounds to zero leaves the hue at zero.
      if (sd.hue_zero || quo_sat == '0) begin
         out_hue = '0;
      end else if (sd.hue_neg) begin
         out_hue = sd.hue_base - 15'(quo_hue);
      end else begin
         out_hue = sd.hue_base + 15'(quo_hue);
      end
      out_sat = sd.top_zero ? '0 : quo_sat[12:0];
      if (ctrl_ff[cshn_pkg::CTRL_NORM]) begin
         case (sd.lv_code)
            cshn_pkg::LV_ZERO: out_level = '0;
            cshn_pkg::LV_SAT:  out_level = sd.lv_neg ? -$signed(cshn_pkg::LEVEL_ONE)
                                                     : $signed(cshn_pkg::LEVEL_ONE);
            default:           out_level = sd.lv_neg ? -$signed({2'b00, quo_lv})
                                                     : $signed({2'b00, quo_lv});
         endcase
      end else begin
         out_level = $signed({1'b0, sd.bright});
      end
   end

   logic               o_color_ff;
   logic [14:0]        o_r_ff, o_g_ff, o_b_ff, o_hue_ff, o_bright_ff;
   logic [12:0]        o_sat_ff;
   logic [15:0]        o_value_ff;
   logic signed [15:0] o_level_ff;

   always_ff @(posedge clock) begin
      if (stg_en[P_OUT]) begin
         o_color_ff  <= color_mode;
         o_r_ff      <= sd.nr;
         o_g_ff      <= sd.ng;
         o_b_ff      <= sd.nb;
         o_hue_ff    <= color_mode ? out_hue : '0;
         o_sat_ff    <= color_mode ? out_sat : '0;
         o_value_ff  <= color_mode ? sd.value : '0;
         o_bright_ff <= sd.bright;
         o_level_ff  <= out_level;
      end
   end

   assign rsp_color_valid      = o_color_ff;
   assign rsp_norm_red         = o_r_ff;
   assign rsp_norm_green       = o_g_ff;
   assign rsp_norm_blue        = o_b_ff;
   assign rsp_hue              = o_hue_ff;
   assign rsp_saturation       = o_sat_ff;
   assign rsp_value            = o_value_ff;
   assign rsp_brightness       = o_bright_ff;
   assign rsp_brightness_level = o_level_ff;

   // ----------------------------------------------------------- assertions
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the pipeline had room");

   a_gray_has_no_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("hue reported for a beat with zero saturation");

   a_reflect_mode_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_color_valid) |->
         (rsp_norm_red == '0 && rsp_hue == '0 && rsp_value == '0))
      else $error("color fields set on a reflect mode beat");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ============================================================================
// Color sensor HSV normalizer testbench
// Runs a table of directed readings and then random calibration phases
// through the block, predicting each result beat or taking it from the table,
// and checks it field by field while both handshake sides idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb;

   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_ITEMS  = 170;

   typedef struct packed {
      logic        color_valid;
      logic [14:0] norm_red;
      logic [14:0] norm_green;
      logic [14:0] norm_blue;
      logic [14:0] hue;
      logic [12:0] saturation;
      logic [15:0] value;
      logic [14:0] brightness;
      logic [15:0] level;
   } reading_type;

   typedef struct {
      logic [2:0]  flags;
      logic [9:0]  red;
      logic [9:0]  green;
      logic [9:0]  blue;
      logic [6:0]  reflect;
      bit          typed;
      reading_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = cshn_pkg::CFG_CONTROL;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [9:0] req_raw_red = '0;
   logic [9:0] req_raw_green = '0;
   logic [9:0] req_raw_blue = '0;
   logic [6:0] req_reflect = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_color_valid;
   logic [14:0] rsp_norm_red, rsp_norm_green, rsp_norm_blue, rsp_hue, rsp_brightness;
   logic [12:0] rsp_saturation;
   logic [15:0] rsp_value;
   logic signed [15:0] rsp_brightness_level;

   color_sensor_hsv_normalizer_unit u_top (.*);

   always #4 clock = ~clock;

   // Shadow of the calibration registers.
   logic [2:0]  mode_flags;
   logic [9:0]  cal_black [3];
   logic [9:0]  cal_white [3];
   logic [15:0] refl_limits;

   reading_type pending_readings [$];
   int  snd_idle = 0;
   int  rcv_idle = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   int  cycles = 0;
   bit  failed = 1'b0;

   function automatic longint round_div(longint n, longint d);
      if (n < 0) return -((2 * (-n) + d) / (2 * d));
      return (2 * n + d) / (2 * d);
   endfunction

   function automatic longint channel_pct(longint raw, longint black, longint white);
      longint n, d;
      n = raw - black;
      d = white - black;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (d == 0) return (n > 0) ? 25600 : 0;
      if (n <= 0) return 0;
      if (n >= d) return 25600;
      return round_div(n * 25600, d);
   endfunction

   function automatic longint level_about_mid(longint br, longint lo, longint hi);
      longint n, d, q;
      n = 2 * br - lo - hi;
      d = hi - lo;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (d == 0) return (n > 0) ? 16384 : ((n < 0) ? -16384 : 0);
      q = round_div(n * 16384, d);
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q;
   endfunction

   function automatic longint hue_term(longint num, longint den, longint base);
      return base * 64 + round_div(3840 * num, den);
   endfunction

   function automatic longint sat_frac(longint diff, longint top);
      if (top == 0) return 0;
      return round_div(diff * 4096, top);
   endfunction

   function automatic reading_type predict_reading(logic [9:0] rr, logic [9:0] rg,
                                                   logic [9:0] rb, logic [6:0] refl);
      reading_type res;
      longint nr, ng, nb, r, g, b, off, h, s, v, br, lv;
      res = '0;
      nr = 0; ng = 0; nb = 0; h = 0; s = 0; v = 0;
      if (mode_flags[cshn_pkg::CTRL_COLOR]) begin
         off = mode_flags[cshn_pkg::CTRL_OFFSET] ? 7680 : 0;
         nr = channel_pct(rr, cal_black[0], cal_white[0]);
         ng = channel_pct(rg, cal_black[1], cal_white[1]);
         nb = channel_pct(rb, cal_black[2], cal_white[2]);
         r = nr + off; g = ng + off; b = nb + off;
         // Every matching sector overwrites the earlier ones.
         if (r >= g && g >= b) begin
            v = r; s = sat_frac(r - b, r);
            if (r == b) h = 0; else if (s != 0) h = hue_term(g - b, r - b, 0);
         end
         if (r >= b && b >= g) begin
            v = r; s = sat_frac(r - g, r);
            if (r == g) h = 0; else if (s != 0) h = hue_term(g - b, r - g, 360);
         end
         if (g >= r && r >= b) begin
            v = g; s = sat_frac(g - b, g);
            if (g == b) h = 0; else if (s != 0) h = hue_term(b - r, g - b, 120);
         end
         if (g >= b && b >= r) begin
            v = g; s = sat_frac(g - r, g);
            if (r == g) h = 0; else if (s != 0) h = hue_term(b - r, g - r, 120);
         end
         if (b >= r && r >= g) begin
            v = b; s = sat_frac(b - g, b);
            if (g == b) h = 0; else if (s != 0) h = hue_term(r - g, b - g, 240);
         end
         if (b >= g && g >= r) begin
            v = b; s = sat_frac(b - r, b);
            if (r == b) h = 0; else if (s != 0) h = hue_term(r - g, b - r, 240);
         end
         br = (19589 * nr + 38444 * ng + 7502 * nb + 32768) >>> 16;
         lv = level_about_mid(br, 0, 25600);
         res.color_valid = 1'b1;
      end else begin
         br = longint'(refl) * 256;
         lv = level_about_mid(refl, refl_limits[7:0], refl_limits[15:8]);
      end
      if (!mode_flags[cshn_pkg::CTRL_NORM]) lv = br;
      res.norm_red   = nr[14:0];
      res.norm_green = ng[14:0];
      res.norm_blue  = nb[14:0];
      res.hue        = h[14:0];
      res.saturation = s[12:0];
      res.value      = v[15:0];
      res.brightness = br[14:0];
      res.level      = lv[15:0];
      return res;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endtask

   // Result side: checks each beat and drives the stall.
   always @(posedge clock) begin
      reading_type exp_rd;
      cycles <= cycles + 1;
      if (rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("result beat with no reading outstanding");
            failed = 1'b1;
         end else begin
            exp_rd = pending_readings.pop_front();
            check_field("color_valid", exp_rd.color_valid, rsp_color_valid);
            check_field("norm_red", exp_rd.norm_red, rsp_norm_red);
            check_field("norm_green", exp_rd.norm_green, rsp_norm_green);
            check_field("norm_blue", exp_rd.norm_blue, rsp_norm_blue);
            check_field("hue", exp_rd.hue, rsp_hue);
            check_field("saturation", exp_rd.saturation, rsp_saturation);
            check_field("value", exp_rd.value, rsp_value);
            check_field("brightness", exp_rd.brightness, rsp_brightness);
            check_field("brightness_level", longint'($signed(exp_rd.level)),
                        rsp_brightness_level);
         end
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         cshn_pkg::CFG_CONTROL:        mode_flags = data[2:0];
         cshn_pkg::CFG_BLACK_RED:      cal_black[0] = data[9:0];
         cshn_pkg::CFG_WHITE_RED:      cal_white[0] = data[9:0];
         cshn_pkg::CFG_BLACK_GREEN:    cal_black[1] = data[9:0];
         cshn_pkg::CFG_WHITE_GREEN:    cal_white[1] = data[9:0];
         cshn_pkg::CFG_BLACK_BLUE:     cal_black[2] = data[9:0];
         cshn_pkg::CFG_WHITE_BLUE:     cal_white[2] = data[9:0];
         cshn_pkg::CFG_REFLECT_LIMITS: refl_limits = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic offer_reading(logic [9:0] rr, logic [9:0] rg, logic [9:0] rb,
                                logic [6:0] refl, bit typed, reading_type want);
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_red <= rr;
      req_raw_green <= rg;
      req_raw_blue <= rb;
      req_reflect <= refl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_readings.push_back(typed ? want : predict_reading(rr, rg, rb, refl));
   endtask

   function automatic logic [9:0] near_span(int ch);
      int lo, hi;
      lo = (cal_black[ch] < cal_white[ch]) ? cal_black[ch] : cal_white[ch];
      hi = (cal_black[ch] < cal_white[ch]) ? cal_white[ch] : cal_black[ch];
      lo = (lo > 5) ? lo - 5 : 0;
      hi = (hi < 1018) ? hi + 5 : 1023;
      if ($urandom_range(99) < 30) return 10'($urandom);
      return 10'($urandom_range(hi, lo));
   endfunction

   row_type dir_rows [23] = '{
      '{3'd3, 10'd0, 10'd0, 10'd0, 7'd0, 1'b1,
        '{1'b1, 15'd0, 15'd0, 15'd0, 15'd0, 13'd0, 16'd0, 15'd0, 16'hC000}},
      '{3'd3, 10'd1023, 10'd1023, 10'd1023, 7'd0, 1'b1,
        '{1'b1, 15'd25600, 15'd25600, 15'd25600, 15'd0, 13'd0, 16'd25600,
          15'd25600, 16'd16384}},
      '{3'd3, 10'd1023, 10'd0, 10'd0, 7'd0, 1'b0, '0},
      '{3'd3, 10'd0, 10'd1023, 10'd0, 7'd127, 1'b0, '0},
      '{3'd3, 10'd0, 10'd0, 10'd1023, 7'd0, 1'b0, '0},
      '{3'd3, 10'd1023, 10'd1023, 10'd0, 7'd0, 1'b0, '0},
      '{3'd3, 10'd0, 10'd1023, 10'd1023, 7'd0, 1'b0, '0},
      '{3'd3, 10'd1023, 10'd0, 10'd1023, 7'd0, 1'b0, '0},
      '{3'd3, 10'd47, 10'd42, 10'd50, 7'd0, 1'b0, '0},
      '{3'd3, 10'd95, 10'd20, 10'd60, 7'd0, 1'b0, '0},
      '{3'd7, 10'd1023, 10'd0, 10'd0, 7'd0, 1'b0, '0},
      '{3'd7, 10'd0, 10'd0, 10'd0, 7'd0, 1'b0, '0},
      '{3'd7, 10'd30, 10'd80, 10'd10, 7'd0, 1'b0, '0},
      '{3'd1, 10'd50, 10'd40, 10'd20, 7'd0, 1'b0, '0},
      '{3'd0, 10'd1023, 10'd1023, 10'd1023, 7'd100, 1'b1,
        '{1'b0, 15'd0, 15'd0, 15'd0, 15'd0, 13'd0, 16'd0, 15'd25600, 16'd25600}},
      '{3'd0, 10'd0, 10'd0, 10'd0, 7'd0, 1'b1, '0},
      '{3'd0, 10'd0, 10'd0, 10'd0, 7'd127, 1'b1,
        '{1'b0, 15'd0, 15'd0, 15'd0, 15'd0, 13'd0, 16'd0, 15'd32512, 16'd32512}},
      '{3'd2, 10'd0, 10'd0, 10'd0, 7'd21, 1'b1,
        '{1'b0, 15'd0, 15'd0, 15'd0, 15'd0, 13'd0, 16'd0, 15'd5376, 16'd0}},
      '{3'd2, 10'd0, 10'd0, 10'd0, 7'd127, 1'b1,
        '{1'b0, 15'd0, 15'd0, 15'd0, 15'd0, 13'd0, 16'd0, 15'd32512, 16'd16384}},
      '{3'd2, 10'd0, 10'd0, 10'd0, 7'd0, 1'b1,
        '{1'b0, 15'd0, 15'd0, 15'd0, 15'd0, 13'd0, 16'd0, 15'd0, 16'hC000}},
      '{3'd2, 10'd0, 10'd0, 10'd0, 7'd6, 1'b0, '0},
      '{3'd6, 10'd0, 10'd0, 10'd0, 7'd64, 1'b0, '0},
      '{3'd5, 10'd512, 10'd300, 10'd700, 7'd33, 1'b0, '0}
   };

   logic [2:0] phase_flags [8] = '{3'd3, 3'd7, 3'd0, 3'd2, 3'd1, 3'd5, 3'd6, 3'd4};

   initial begin
      logic [9:0] blk, wht;
      logic [15:0] lim;
      mode_flags = cshn_pkg::CONTROL_RESET;
      cal_black = '{cshn_pkg::BLACK_RED_RESET, cshn_pkg::BLACK_GREEN_RESET,
                    cshn_pkg::BLACK_BLUE_RESET};
      cal_white = '{cshn_pkg::WHITE_RED_RESET, cshn_pkg::WHITE_GREEN_RESET,
                    cshn_pkg::WHITE_BLUE_RESET};
      refl_limits = cshn_pkg::REFLECT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_idle = 12;
      rcv_idle = 68;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].flags != mode_flags) begin
            wait_all_results();
            write_reg(cshn_pkg::CFG_CONTROL, {13'($urandom), dir_rows[i].flags});
         end
         offer_reading(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                       dir_rows[i].reflect, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int p = 0; p < 8; p++) begin
         wait_all_results();
         if (p == 3) begin
            snd_idle = 68;
            rcv_idle = 12;
         end else if (p == 6) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         write_reg(cshn_pkg::CFG_CONTROL, {13'($urandom), phase_flags[p]});
         for (int ch = 0; ch < 3; ch++) begin
            case (p % 4)
               // Ordinary spans.
               0, 2: begin
                  blk = 10'($urandom_range(200));
                  wht = 10'($urandom_range(1023, blk + 20));
               end
               // Inverted span at the widest extreme, or a zero span.
               1: begin
                  blk = (ch == 1) ? 10'd700 : 10'd1023;
                  wht = (ch == 1) ? 10'd700 : 10'd0;
               end
               default: begin
                  blk = 10'($urandom);
                  wht = 10'($urandom);
               end
            endcase
            write_reg(3'(1 + 2 * ch), {6'($urandom), blk});
            write_reg(3'(2 + 2 * ch), {6'($urandom), wht});
         end
         case (p % 4)
            0: lim = 16'hFF00;
            1: lim = {8'd50, 8'd50};
            2: lim = {8'd10, 8'd90};
            default: lim = 16'($urandom);
         endcase
         write_reg(cshn_pkg::CFG_REFLECT_LIMITS, lim);
         if (p == 7) hold_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == 80) wait_all_results();
            offer_reading(near_span(0), near_span(1), near_span(2),
                          7'($urandom), 1'b0, '0);
         end
      end

      wait_all_results();
      if (!failed && pending_readings.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
src/cshn_pkg.sv
src/cshn_div_pipe.sv
src/color_sensor_hsv_normalizer_unit.sv
bench/tb.sv
